// File: design/astcw_pkg.sv
// Shared types and constants for the ANSI SGR text cell writer.
// No dependencies; used by every astcw_* module and the top level.
package astcw_pkg;

    localparam int SCREEN_COLUMNS   = 80;
    localparam int CLEAR_LINE_LIMIT = 25;
    localparam int MAX_SGR_CODES    = 4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] CLEAR_ATTR = 8'h0F;

    localparam logic [7:0] FG_LO     = 8'd30;
    localparam logic [7:0] FG_HI     = 8'd37;
    localparam logic [7:0] FG_BRT_LO = 8'd90;
    localparam logic [7:0] FG_BRT_HI = 8'd97;
    localparam logic [7:0] BG_LO     = 8'd40;
    localparam logic [7:0] BG_HI     = 8'd47;

    typedef enum logic [3:0] {
        MODE_TEXT = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_SGR  = 4'b0100,
        MODE_IDLE = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [11:0] cell_index;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attribute;
        logic        write_cell;
        logic        clear_screen;
    } t_result;

    // one queue entry = all results of one item (one or two)
    typedef struct packed {
        logic    two;
        t_result res1;
        t_result res0;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_head;

    typedef struct packed {
        logic [4:0] fg;         // bit 4 = valid
        logic [2:0] bg;
        logic       bg_valid;
        logic       reset_seen;
    } t_pend;

    // ANSI color number to VGA color number
    function automatic logic [2:0] vga_colour(input logic [2:0] ansi);
        logic [2:0] v;
        case (ansi)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd2;
            3'd3:    v = 3'd6;
            3'd4:    v = 3'd1;
            3'd5:    v = 3'd5;
            3'd6:    v = 3'd3;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

endpackage

// File: design/astcw_front.sv
// Front end: accepts characters, runs the SGR parser and cursor state,
// and pushes the results of each item into the queue. Uses astcw_pkg.
module astcw_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_char_byte,
    input  logic                   i_first,
    input  logic [5:0]             i_start_line,
    input  logic [6:0]             i_start_column,
    input  logic [7:0]             i_base_attribute,
    input  logic                   i_full,
    output astcw_pkg::t_push       o_push
);

    astcw_pkg::t_mode r_mode, n_mode;
    logic [11:0]      r_cell, n_cell;
    logic [5:0]       r_line, n_line;
    logic [5:0]       r_used, n_used;
    logic [7:0]       r_def, n_def;
    logic [7:0]       r_act, n_act;
    logic [7:0]       r_acc, n_acc;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_start, n_start;
    astcw_pkg::t_pend r_pend, n_pend;

    logic        w_accept;
    logic        w_digit;
    logic [3:0]  w_dval;
    logic [11:0] w_acc_mul;
    logic [11:0] w_start_cell;
    logic        w_clr, w_esc_wr, w_do_text, w_txt_wr, w_go_b, w_apply;
    logic [11:0] w_esc_cell, w_txt_cell;
    astcw_pkg::t_mode w_mode_eff;
    astcw_pkg::t_result w_res_clr, w_res_esc, w_res_txt;

    function automatic astcw_pkg::t_pend store_code(input astcw_pkg::t_pend p,
                                                    input logic [7:0] v);
        astcw_pkg::t_pend q;
        logic [7:0] d;
        q = p;
        d = 8'd0;
        if (v == 8'd0) begin
            q.reset_seen = 1'b1;
        end else if (v >= astcw_pkg::FG_LO && v <= astcw_pkg::FG_HI) begin
            d    = v - astcw_pkg::FG_LO;
            q.fg = {2'b10, astcw_pkg::vga_colour(d[2:0])};
        end else if (v >= astcw_pkg::FG_BRT_LO && v <= astcw_pkg::FG_BRT_HI) begin
            d    = v - astcw_pkg::FG_BRT_LO;
            q.fg = {2'b11, astcw_pkg::vga_colour(d[2:0])};
        end else if (v >= astcw_pkg::BG_LO && v <= astcw_pkg::BG_HI) begin
            d          = v - astcw_pkg::BG_LO;
            q.bg       = d[2:0];
            q.bg_valid = 1'b1;
        end
        return q;
    endfunction

    // attribute after a sequence ends; unchanged when nothing usable was read
    function automatic logic [7:0] apply_attr(input astcw_pkg::t_pend p,
                                              input logic [7:0] act,
                                              input logic [7:0] def);
        logic [7:0] a;
        a = act;
        if (p.fg[4] && p.bg_valid)  a = {1'b0, p.bg, p.fg[3:0]};
        else if (p.fg[4])           a = {4'h0, p.fg[3:0]};
        else if (p.bg_valid)        a = {1'b0, p.bg, 4'h0};
        else if (p.reset_seen)      a = def;
        return a;
    endfunction

    function automatic logic [5:0] sat_inc(input logic [5:0] x);
        return (x == 6'h3F) ? x : x + 6'd1;
    endfunction

    function automatic logic [2:0] cnt_inc(input logic [2:0] x);
        return (x == 3'h7) ? x : x + 3'd1;
    endfunction

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    assign w_digit   = (i_char_byte >= astcw_pkg::CH_ZERO) && (i_char_byte <= astcw_pkg::CH_NINE);
    assign w_dval    = i_char_byte[3:0];
    assign w_acc_mul = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {8'h00, w_dval};
    assign w_start_cell = 12'(int'(i_start_line) * astcw_pkg::SCREEN_COLUMNS
                              + int'(i_start_column));

    always_comb begin
        n_mode     = r_mode;
        n_cell     = r_cell;
        n_line     = r_line;
        n_used     = r_used;
        n_def      = r_def;
        n_act      = r_act;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_start    = r_start;
        n_pend     = r_pend;
        w_clr      = 1'b0;
        w_esc_wr   = 1'b0;
        w_do_text  = 1'b0;
        w_txt_wr   = 1'b0;
        w_go_b     = 1'b0;
        w_apply    = 1'b0;
        w_mode_eff = r_mode;

        if (i_first) begin
            n_pend  = '0;
            n_acc   = 8'd0;
            n_cnt   = 3'd0;
            n_start = 1'b1;
            n_mode  = astcw_pkg::MODE_TEXT;
            if (r_used > 6'(astcw_pkg::CLEAR_LINE_LIMIT)) begin
                n_used = 6'd0;
                w_clr  = 1'b1;
            end
            n_line     = i_start_line;
            n_cell     = w_start_cell;
            n_def      = i_base_attribute;
            n_act      = i_base_attribute;
            w_mode_eff = astcw_pkg::MODE_TEXT;
        end

        unique case (w_mode_eff)
            astcw_pkg::MODE_TEXT: begin
                w_do_text = 1'b1;
            end
            astcw_pkg::MODE_ESC: begin
                if (i_char_byte == astcw_pkg::CH_LBR) begin
                    n_pend  = '0;
                    n_acc   = 8'd0;
                    n_cnt   = 3'd0;
                    n_start = 1'b1;
                    n_mode  = astcw_pkg::MODE_SGR;
                end else begin
                    n_mode    = astcw_pkg::MODE_TEXT;
                    w_esc_wr  = 1'b1;
                    w_do_text = 1'b1;
                end
            end
            astcw_pkg::MODE_SGR: begin
                // inside a code: digits accumulate, anything else closes it
                if (!n_start) begin
                    if (w_digit) begin
                        n_acc = (w_acc_mul > 12'd255) ? 8'd255 : w_acc_mul[7:0];
                    end else begin
                        n_pend  = store_code(n_pend, n_acc);
                        n_cnt   = cnt_inc(n_cnt);
                        n_acc   = 8'd0;
                        n_start = 1'b1;
                        w_go_b  = (i_char_byte != astcw_pkg::CH_SEMI);
                    end
                end else begin
                    w_go_b = 1'b1;
                end
                // at a code boundary
                if (w_go_b) begin
                    if (n_cnt >= 3'(astcw_pkg::MAX_SGR_CODES)
                        || i_char_byte == astcw_pkg::CH_M
                        || i_char_byte == astcw_pkg::CH_NUL) begin
                        w_apply   = 1'b1;
                        w_do_text = (i_char_byte != astcw_pkg::CH_M);
                    end else if (w_digit) begin
                        n_acc   = {4'h0, w_dval};
                        n_start = 1'b0;
                    end else if (i_char_byte == astcw_pkg::CH_SEMI) begin
                        n_pend.reset_seen = 1'b1;
                        n_cnt             = cnt_inc(n_cnt);
                    end else begin
                        // odd byte: empty slots count as code 0, then text
                        n_pend.reset_seen = 1'b1;
                        w_apply           = 1'b1;
                        w_do_text         = 1'b1;
                    end
                end
                if (w_apply) begin
                    n_act   = apply_attr(n_pend, n_act, n_def);
                    n_pend  = '0;
                    n_acc   = 8'd0;
                    n_cnt   = 3'd0;
                    n_start = 1'b1;
                    n_mode  = astcw_pkg::MODE_TEXT;
                end
            end
            astcw_pkg::MODE_IDLE: begin
                // message ended; wait for the next first character
            end
            default: begin
            end
        endcase

        w_esc_cell = n_cell;
        w_txt_cell = n_cell + {11'd0, w_esc_wr};
        n_cell     = w_txt_cell;

        if (w_do_text) begin
            if (i_char_byte == astcw_pkg::CH_NUL) begin
                n_used = sat_inc(n_used);
                n_mode = astcw_pkg::MODE_IDLE;
            end else if (i_char_byte == astcw_pkg::CH_ESC) begin
                n_mode = astcw_pkg::MODE_ESC;
            end else if (i_char_byte == astcw_pkg::CH_LF) begin
                n_line = sat_inc(n_line);
                n_cell = 12'(int'(n_line) * astcw_pkg::SCREEN_COLUMNS);
                n_used = sat_inc(n_used);
            end else begin
                w_txt_wr = 1'b1;
                n_cell   = w_txt_cell + 12'd1;
            end
        end
    end

    always_comb begin
        w_res_clr = '{cell_index: 12'd0, cell_char: astcw_pkg::CH_SPACE,
                      cell_attribute: astcw_pkg::CLEAR_ATTR,
                      write_cell: 1'b0, clear_screen: 1'b1};
        w_res_esc = '{cell_index: w_esc_cell, cell_char: astcw_pkg::CH_ESC,
                      cell_attribute: n_act, write_cell: 1'b1, clear_screen: 1'b0};
        w_res_txt = '{cell_index: w_txt_cell, cell_char: i_char_byte,
                      cell_attribute: n_act, write_cell: 1'b1, clear_screen: 1'b0};
        o_push.push     = w_accept && (w_clr || w_esc_wr || w_txt_wr);
        o_push.ent.res0 = w_clr ? w_res_clr : (w_esc_wr ? w_res_esc : w_res_txt);
        o_push.ent.res1 = w_res_txt;
        o_push.ent.two  = (w_clr || w_esc_wr) && w_txt_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= astcw_pkg::MODE_TEXT;
            r_cell  <= 12'd0;
            r_line  <= 6'd0;
            r_used  <= 6'd0;
            r_def   <= 8'd0;
            r_act   <= 8'd0;
            r_acc   <= 8'd0;
            r_cnt   <= 3'd0;
            r_start <= 1'b1;
            r_pend  <= '0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_cell  <= n_cell;
            r_line  <= n_line;
            r_used  <= n_used;
            r_def   <= n_def;
            r_act   <= n_act;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_start <= n_start;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: design/astcw_queue.sv
// Small FIFO of per-item result groups between front and back end.
// Uses astcw_pkg for the entry types.
module astcw_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  astcw_pkg::t_push i_push,
    output logic             o_full,
    output astcw_pkg::t_head o_head,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    astcw_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ent   = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) r_wr <= ptr_inc(r_wr);
            if (w_pop)       r_rd <= ptr_inc(r_rd);
            if (i_push.push && !w_pop)      r_count <= r_count + CW'(1);
            else if (!i_push.push && w_pop) r_count <= r_count - CW'(1);
        end
    end

endmodule

// File: design/astcw_back.sv
// Back end: walks the one or two results of the head queue entry into a
// registered output stage with last marking. Uses astcw_pkg.
module astcw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  astcw_pkg::t_head     i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output astcw_pkg::t_result   o_result,
    output logic                 o_last
);

    logic               r_valid;
    logic               r_idx;
    logic               r_last;
    astcw_pkg::t_result r_result;
    logic               w_load;
    logic               w_ent_last;

    assign w_load     = !r_valid || i_ready;
    assign w_ent_last = r_idx || !i_head.ent.two;
    assign o_pop      = w_load && i_head.valid && w_ent_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_head.valid;
            if (i_head.valid) r_idx <= !w_ent_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_head.valid) begin
            r_result <= r_idx ? i_head.ent.res1 : i_head.ent.res0;
            r_last   <= w_ent_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

endmodule

// File: design/ansi_sgr_text_cell_writer.sv
// Top level of the ANSI SGR text cell writer: front parser, result queue,
// output sequencer. Depends on astcw_pkg, astcw_front, astcw_queue, astcw_back.
//
// Usage:
//  - s_axis carries one message character per item; tuser[0] flags the first
//    character, which also loads start line/column and the base attribute.
//  - m_axis carries cell writes and clear requests; tlast marks the last
//    result of one input item (an item gives zero, one or two results).
//  - Path: a taken item is parsed and written into the queue, then its result
//    is loaded into the output register before it leaves on m_axis.
//  - Throughput: one item per cycle while each item gives at most one result and
//    m_axis_tready stays high; the output port sends one result per cycle, so two-result items
//    (clear plus write, or a lone ESC plus the next character) send their results one after the other.
//    The single output register is the limit.
//  - Items with no result (escape bytes, newlines, terminator, bytes after the
//    terminator) pass through the parser and put nothing in the queue.
//  - m_axis stall: results pile up in the QUEUE_DEPTH-entry queue; s_axis_tready
//    drops only when the queue is full, so the input side keeps going meanwhile.
//  - Reset (i_rst_n low, synchronous): parser returns to text mode, cursor at
//    cell 0, attributes 0, queue and output register empty.
module ansi_sgr_text_cell_writer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_byte, [13:8] start_line, [20:14] start_column,
    // [28:21] base_attribute, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [0] first_of_message
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] cell_index, [19:12] cell_char, [27:20] cell_attribute, [31:28] zero
    output logic [31:0] m_axis_tdata,
    // [0] write_cell, [1] clear_screen
    output logic [1:0]  m_axis_tuser,
    // last_result
    output logic        m_axis_tlast
);

    astcw_pkg::t_push   w_push;
    astcw_pkg::t_head   w_head;
    astcw_pkg::t_result w_result;
    logic               w_full;
    logic               w_pop;

    // parser and cursor state
    astcw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_char_byte      (s_axis_tdata[7:0]),
        .i_first          (s_axis_tuser[0]),
        .i_start_line     (s_axis_tdata[13:8]),
        .i_start_column   (s_axis_tdata[20:14]),
        .i_base_attribute (s_axis_tdata[28:21]),
        .i_full           (w_full),
        .o_push           (w_push)
    );

    // decouples parser from output stalls
    astcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // splits each entry into its results, one per cycle while m_axis is not stalled
    astcw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, w_result.cell_attribute, w_result.cell_char,
                           w_result.cell_index};
    assign m_axis_tuser = {w_result.clear_screen, w_result.write_cell};

`ifndef SYNTHESIS
    // output stage comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // first result of a two-result item is followed at once by the second
    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of an item did not follow");

    // a clear request is never a cell write and always names cell 0
    a_clear_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            !m_axis_tuser[0] && m_axis_tdata[11:0] == 12'd0)
        else $error("malformed clear result");
`endif

endmodule
